### rtl/hts_pkg.sv
// ----------------------------------------------------------------------------
// hts_pkg
// Shared widths, reset values, register indexes and unit control types for
// the Hugoniot thermostat stepper.
// ----------------------------------------------------------------------------
package hts_pkg;

  // fixed point format
  localparam int FRAC_BITS  = 16;
  localparam int MAX_WINDOW = 256;

  // field and state widths
  localparam int DATA_W    = 32;
  localparam int DIFF_W    = DATA_W + 1;
  localparam int PROD_W    = 2 * DIFF_W;
  localparam int HP_W      = PROD_W + 1 - (FRAC_BITS + 1);
  localparam int DEV_W     = 40;
  localparam int SUM_W     = 48;
  localparam int CNT_W     = 9;
  localparam int REM_W     = CNT_W + 1;
  localparam int UPD_W     = 8;
  localparam int CFG_IDX_W = 3;

  // serial unit step counts
  localparam int STEP_CNT_W = 6;
  localparam logic [STEP_CNT_W-1:0] MUL_STEPS = STEP_CNT_W'(DIFF_W);
  localparam logic [STEP_CNT_W-1:0] DIV_STEPS = STEP_CNT_W'(SUM_W);

  // reset values
  localparam logic [DATA_W-1:0] STEP_RESET = DATA_W'(10 << FRAC_BITS);
  localparam logic [UPD_W-1:0]  UPD_RESET  = UPD_W'(5);

  // 32 bit limits
  localparam logic [DATA_W-1:0] DATA_MAX = {1'b0, {(DATA_W-1){1'b1}}};
  localparam logic [DATA_W-1:0] DATA_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_REF_ENERGY   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_REF_VOLUME   = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_REF_PRESSURE = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_UPDATE_EVERY = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_STEP = CFG_IDX_W'(4);

  // serial unit operation
  typedef enum logic {
    UNIT_MUL,
    UNIT_DIV
  } unit_op_e;

  typedef struct packed {
    logic     start;
    unit_op_e op;
  } unit_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

### rtl/hts_serial_unit.sv
// ----------------------------------------------------------------------------
// hts_serial_unit
// Shared bit-serial arithmetic unit: one adder drives either a shift-add
// magnitude multiply (one multiplier bit per cycle) or a restoring divide
// (one quotient bit per cycle).
// ----------------------------------------------------------------------------
module hts_serial_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hts_pkg::unit_ctrl_t                 ctrl_i,
  input  logic [hts_pkg::SUM_W-1:0]           opa_i,
  input  logic [hts_pkg::DIFF_W-1:0]          opb_i,
  output hts_pkg::unit_stat_t                 stat_o,
  output logic [hts_pkg::PROD_W-1:0]          result_o
);
  import hts_pkg::*;

  unit_op_e              op_q, op_d;
  logic [DIFF_W-1:0]     b_q, b_d;
  logic [PROD_W-1:0]     w_q, w_d;
  logic [STEP_CNT_W-1:0] cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;

  logic [DIFF_W:0]       add_a, add_b, add_y;
  logic                  add_sub;
  logic [REM_W:0]        shifted;
  logic [DIFF_W:0]       hi_new;
  logic                  fits;
  logic [REM_W-1:0]      rem_new;

  // shared adder
  assign add_y = add_a + (add_sub ? ~add_b : add_b) + {{DIFF_W{1'b0}}, add_sub};

  // operand selection for the adder
  always_comb begin
    shifted = {w_q[SUM_W+REM_W-1:SUM_W], w_q[SUM_W-1]};
    add_b   = {1'b0, b_q};
    if (op_q == UNIT_DIV) begin
      add_a   = (DIFF_W+1)'(shifted);
      add_sub = 1'b1;
    end else begin
      add_a   = {1'b0, w_q[PROD_W-1:DIFF_W]};
      add_sub = 1'b0;
    end
  end

  // step and start sequencing
  always_comb begin
    op_d    = op_q;
    b_d     = b_q;
    w_d     = w_q;
    cnt_d   = cnt_q;
    busy_d  = busy_q;
    done_d  = 1'b0;
    hi_new  = w_q[0] ? add_y : {1'b0, w_q[PROD_W-1:DIFF_W]};
    fits    = ~add_y[DIFF_W];
    rem_new = fits ? add_y[REM_W-1:0] : shifted[REM_W-1:0];
    if (ctrl_i.start) begin
      op_d   = ctrl_i.op;
      b_d    = opb_i;
      busy_d = 1'b1;
      if (ctrl_i.op == UNIT_DIV) begin
        w_d   = {(PROD_W-SUM_W)'(0), opa_i};
        cnt_d = DIV_STEPS;
      end else begin
        w_d   = {(PROD_W-DIFF_W)'(0), opa_i[DIFF_W-1:0]};
        cnt_d = MUL_STEPS;
      end
    end else if (busy_q) begin
      if (op_q == UNIT_DIV) begin
        w_d = {(PROD_W-REM_W-SUM_W)'(0), rem_new, w_q[SUM_W-2:0], fits};
      end else begin
        w_d = {hi_new, w_q[DIFF_W-1:1]};
      end
      cnt_d = cnt_q - STEP_CNT_W'(1);
      if (cnt_q == STEP_CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      op_q   <= UNIT_MUL;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
      op_q   <= op_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    b_q <= b_d;
    w_q <= w_d;
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = w_q;

endmodule

### rtl/hugoniot_thermostat_stepper_unit.sv
// ----------------------------------------------------------------------------
// hugoniot_thermostat_stepper_unit
// Hugoniot deviation per sample, windowed average and adaptive setpoint step.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  in      | input     | in_valid_i/in_stall_o | energy, cell_volume,
//          |           |                       | pressure_sample, setpoint_in
//  out     | output    | out_valid_o/out_stall_i | setpoint_out, deviation,
//          |           |                       | did_update, window_average
//  cfg     | input     | cfg_we_i              | cfg_idx_i, cfg_data_i
//
//  a word without an update runs the 33 step serial multiply; a word
//  that closes a window adds the 48 step serial divide and the step
//  decision.
//  one word is in work at a time; in_stall_o is high while it is.
//  the finished word waits in the output register, so a new word is taken
//  while out_stall_i holds the previous result. reset clears the window,
//  the references and out_valid_o, and reloads the step size and interval.
// ----------------------------------------------------------------------------
module hugoniot_thermostat_stepper_unit (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic signed [hts_pkg::DATA_W-1:0]     energy_i,
  input  logic signed [hts_pkg::DATA_W-1:0]     cell_volume_i,
  input  logic signed [hts_pkg::DATA_W-1:0]     pressure_sample_i,
  input  logic signed [hts_pkg::DATA_W-1:0]     setpoint_in_i,
  // result words
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [hts_pkg::DATA_W-1:0]     setpoint_out_o,
  output logic signed [hts_pkg::DEV_W-1:0]      deviation_o,
  output logic                                  did_update_o,
  output logic signed [hts_pkg::DEV_W-1:0]      window_average_o,
  // configuration
  input  logic                                  cfg_we_i,
  input  logic [hts_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [hts_pkg::DATA_W-1:0]            cfg_data_i
);
  import hts_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_MUL   = 4'd2;
  localparam logic [3:0] S_FIX   = 4'd3;
  localparam logic [3:0] S_DEV   = 4'd4;
  localparam logic [3:0] S_ACC   = 4'd5;
  localparam logic [3:0] S_DIVLD = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_AVG   = 4'd8;
  localparam logic [3:0] S_STEP  = 4'd9;
  localparam logic [3:0] S_ADD   = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]               state_q, state_d;

  // configuration
  logic [DATA_W-1:0]        ref_e_q, ref_e_d;
  logic [DATA_W-1:0]        ref_v_q, ref_v_d;
  logic [DATA_W-1:0]        ref_p_q, ref_p_d;
  logic [UPD_W-1:0]         upd_every_q, upd_every_d;

  // window state
  logic [SUM_W-1:0]         sum_q, sum_d;
  logic [CNT_W-1:0]         cnt_q, cnt_d;
  logic [DEV_W-1:0]         prev_avg_q, prev_avg_d;
  logic [DATA_W-1:0]        step_q, step_d;
  logic                     first_q, first_d;

  // per word working registers
  logic [DIFF_W-1:0]        de_q, de_d, dv_q, dv_d, dp_q, dp_d;
  logic [DATA_W-1:0]        setpoint_q, setpoint_d;
  logic                     neg_q, neg_d;
  logic [HP_W-1:0]          hp_q, hp_d;
  logic [DEV_W-1:0]         h_q, h_d;
  logic [DEV_W-1:0]         avg_q, avg_d;
  logic                     upd_q, upd_d;
  logic                     add_q, add_d;

  // output register
  logic                     out_valid_q, out_valid_d;
  logic [DATA_W-1:0]        out_setpoint_q, out_setpoint_d;
  logic [DEV_W-1:0]         out_dev_q, out_dev_d;
  logic                     out_upd_q, out_upd_d;
  logic [DEV_W-1:0]         out_avg_q, out_avg_d;

  // serial unit
  unit_ctrl_t               unit_ctrl;
  unit_stat_t               unit_stat;
  logic [SUM_W-1:0]         unit_opa;
  logic [DIFF_W-1:0]        unit_opb;
  logic [PROD_W-1:0]        unit_res;

  // datapath helpers
  logic                     in_take;
  logic [DIFF_W-1:0]        mag_v, mag_p;
  logic [SUM_W-1:0]         mag_sum;
  logic [PROD_W:0]          prod_s;
  logic [HP_W:0]            hsum;
  logic [HP_W-DEV_W+1:0]    hsum_top;
  logic [SUM_W:0]           sum_ext;
  logic [CNT_W-1:0]         cnt_next;
  logic                     win_full;
  logic [SUM_W-1:0]         avg_full;
  logic                     avg_neg, h_neg, prev_neg;
  logic [DEV_W-1:0]         mag_avg, mag_prev;
  logic [DATA_W-1:0]        step_rnd, step_half, step_neg;
  logic [DATA_W:0]          sp_sum;
  logic                     out_free;

  hts_serial_unit u_unit (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (unit_ctrl),
    .opa_i    (unit_opa),
    .opb_i    (unit_opb),
    .stat_o   (unit_stat),
    .result_o (unit_res)
  );

  assign in_take  = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;

  // magnitudes for the serial unit
  assign mag_v   = dv_q[DIFF_W-1] ? (~dv_q + DIFF_W'(1)) : dv_q;
  assign mag_p   = dp_q[DIFF_W-1] ? (~dp_q + DIFF_W'(1)) : dp_q;
  assign mag_sum = sum_q[SUM_W-1] ? (~sum_q + SUM_W'(1)) : sum_q;

  // unit requests
  always_comb begin
    unit_ctrl.start = 1'b0;
    unit_ctrl.op    = UNIT_MUL;
    unit_opa        = {(SUM_W-DIFF_W)'(0), mag_v};
    unit_opb        = mag_p;
    if (state_q == S_LOAD) begin
      unit_ctrl.start = 1'b1;
    end else if (state_q == S_DIVLD) begin
      unit_ctrl.start = 1'b1;
      unit_ctrl.op    = UNIT_DIV;
      unit_opa        = mag_sum;
      unit_opb        = {(DIFF_W-CNT_W)'(0), cnt_q};
    end
  end

  // signed product, deviation and window sums
  assign prod_s   = neg_q ? (~{1'b0, unit_res} + (PROD_W+1)'(1)) : {1'b0, unit_res};
  assign hsum     = {hp_q[HP_W-1], hp_q} + {{(HP_W+1-DIFF_W){de_q[DIFF_W-1]}}, de_q};
  assign hsum_top = hsum[HP_W:DEV_W-1];
  assign sum_ext  = {sum_q[SUM_W-1], sum_q} + {{(SUM_W+1-DEV_W){h_q[DEV_W-1]}}, h_q};
  assign cnt_next = cnt_q + CNT_W'(1);
  assign win_full = (cnt_next > {1'b0, upd_every_q}) || (cnt_next >= CNT_W'(MAX_WINDOW));
  assign avg_full = sum_q[SUM_W-1] ? (~unit_res[SUM_W-1:0] + SUM_W'(1))
                                   : unit_res[SUM_W-1:0];

  // step decision terms
  assign avg_neg   = avg_q[DEV_W-1];
  assign h_neg     = h_q[DEV_W-1];
  assign prev_neg  = prev_avg_q[DEV_W-1];
  assign mag_avg   = avg_neg ? (~avg_q + DEV_W'(1)) : avg_q;
  assign mag_prev  = prev_neg ? (~prev_avg_q + DEV_W'(1)) : prev_avg_q;
  assign step_rnd  = step_q + DATA_W'(step_q[DATA_W-1]);
  assign step_half = {step_rnd[DATA_W-1], step_rnd[DATA_W-1:1]};
  assign step_neg  = (step_q == DATA_MIN) ? DATA_MAX : (~step_q + DATA_W'(1));
  assign sp_sum    = {setpoint_q[DATA_W-1], setpoint_q} + {step_q[DATA_W-1], step_q};

  // sequencer
  always_comb begin
    state_d        = state_q;
    ref_e_d        = ref_e_q;
    ref_v_d        = ref_v_q;
    ref_p_d        = ref_p_q;
    upd_every_d    = upd_every_q;
    sum_d          = sum_q;
    cnt_d          = cnt_q;
    prev_avg_d     = prev_avg_q;
    step_d         = step_q;
    first_d        = first_q;
    de_d           = de_q;
    dv_d           = dv_q;
    dp_d           = dp_q;
    setpoint_d     = setpoint_q;
    neg_d          = neg_q;
    hp_d           = hp_q;
    h_d            = h_q;
    avg_d          = avg_q;
    upd_d          = upd_q;
    add_d          = add_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_setpoint_d = out_setpoint_q;
    out_dev_d      = out_dev_q;
    out_upd_d      = out_upd_q;
    out_avg_d      = out_avg_q;

    case (state_q)
      S_IDLE: begin
        if (in_take) begin
          de_d       = {energy_i[DATA_W-1], energy_i} - {ref_e_q[DATA_W-1], ref_e_q};
          dv_d       = {cell_volume_i[DATA_W-1], cell_volume_i}
                     - {ref_v_q[DATA_W-1], ref_v_q};
          dp_d       = {pressure_sample_i[DATA_W-1], pressure_sample_i}
                     - {ref_p_q[DATA_W-1], ref_p_q};
          setpoint_d = setpoint_in_i;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        neg_d   = dv_q[DIFF_W-1] ^ dp_q[DIFF_W-1];
        state_d = S_MUL;
      end
      S_MUL: begin
        if (unit_stat.done) begin
          state_d = S_FIX;
        end
      end
      // floor of product over two to the FRAC_BITS+1
      S_FIX: begin
        hp_d    = prod_s[PROD_W:FRAC_BITS+1];
        state_d = S_DEV;
      end
      // deviation saturated to the 40 bit range
      S_DEV: begin
        if ((&hsum_top) || !(|hsum_top)) begin
          h_d = hsum[DEV_W-1:0];
        end else begin
          h_d = hsum[HP_W] ? {1'b1, {(DEV_W-1){1'b0}}} : {1'b0, {(DEV_W-1){1'b1}}};
        end
        state_d = S_ACC;
      end
      // accumulate and check the window
      S_ACC: begin
        if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
          sum_d = sum_ext[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
        end else begin
          sum_d = sum_ext[SUM_W-1:0];
        end
        cnt_d   = cnt_next;
        upd_d   = win_full;
        add_d   = 1'b0;
        state_d = win_full ? S_DIVLD : S_OUT;
      end
      S_DIVLD: begin
        state_d = S_DIV;
      end
      S_DIV: begin
        if (unit_stat.done) begin
          state_d = S_AVG;
        end
      end
      // average truncated toward zero, window cleared
      S_AVG: begin
        avg_d   = avg_full[DEV_W-1:0];
        sum_d   = '0;
        cnt_d   = '0;
        state_d = S_STEP;
      end
      // step size rule
      S_STEP: begin
        if (first_q) begin
          first_d = 1'b0;
        end else if (avg_neg != h_neg) begin
          add_d = 1'b0;
        end else if (avg_neg != prev_neg) begin
          step_d = ~step_half + DATA_W'(1);
          add_d  = 1'b1;
        end else begin
          if (mag_avg > mag_prev) begin
            step_d = step_neg;
          end
          add_d = 1'b1;
        end
        prev_avg_d = avg_q;
        state_d    = S_ADD;
      end
      // saturating setpoint move
      S_ADD: begin
        if (add_q) begin
          if (sp_sum[DATA_W] != sp_sum[DATA_W-1]) begin
            setpoint_d = sp_sum[DATA_W] ? DATA_MIN : DATA_MAX;
          end else begin
            setpoint_d = sp_sum[DATA_W-1:0];
          end
        end
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d    = 1'b1;
          out_setpoint_d = setpoint_q;
          out_dev_d      = h_q;
          out_upd_d      = upd_q;
          out_avg_d      = prev_avg_q;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // register writes
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_REF_ENERGY:   ref_e_d     = cfg_data_i;
        CFG_REF_VOLUME:   ref_v_d     = cfg_data_i;
        CFG_REF_PRESSURE: ref_p_d     = cfg_data_i;
        CFG_UPDATE_EVERY: upd_every_d = cfg_data_i[UPD_W-1:0];
        CFG_INITIAL_STEP: step_d      = cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_e_q     <= '0;
      ref_v_q     <= '0;
      ref_p_q     <= '0;
      upd_every_q <= UPD_RESET;
      sum_q       <= '0;
      cnt_q       <= '0;
      prev_avg_q  <= '0;
      step_q      <= STEP_RESET;
      first_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ref_e_q     <= ref_e_d;
      ref_v_q     <= ref_v_d;
      ref_p_q     <= ref_p_d;
      upd_every_q <= upd_every_d;
      sum_q       <= sum_d;
      cnt_q       <= cnt_d;
      prev_avg_q  <= prev_avg_d;
      step_q      <= step_d;
      first_q     <= first_d;
      out_valid_q <= out_valid_d;
    end
  end

  // per word payload
  always_ff @(posedge clk_i) begin
    de_q           <= de_d;
    dv_q           <= dv_d;
    dp_q           <= dp_d;
    setpoint_q     <= setpoint_d;
    neg_q          <= neg_d;
    hp_q           <= hp_d;
    h_q            <= h_d;
    avg_q          <= avg_d;
    upd_q          <= upd_d;
    add_q          <= add_d;
    out_setpoint_q <= out_setpoint_d;
    out_dev_q      <= out_dev_d;
    out_upd_q      <= out_upd_d;
    out_avg_q      <= out_avg_d;
  end

  assign in_stall_o       = (state_q != S_IDLE);
  assign out_valid_o      = out_valid_q;
  assign setpoint_out_o   = out_setpoint_q;
  assign deviation_o      = out_dev_q;
  assign did_update_o     = out_upd_q;
  assign window_average_o = out_avg_q;

endmodule

### rtl/hts_checker.sv
// ----------------------------------------------------------------------------
// hts_checker
// Port level checks for the Hugoniot thermostat stepper, bound to the top.
// ----------------------------------------------------------------------------
module hts_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [hts_pkg::DATA_W-1:0]        setpoint_out_o,
  input logic [hts_pkg::DEV_W-1:0]         deviation_o,
  input logic                              did_update_o,
  input logic [hts_pkg::DEV_W-1:0]         window_average_o
);

  // a stalled result word stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(setpoint_out_o) && $stable(deviation_o)
      && $stable(did_update_o) && $stable(window_average_o))
    else $error("result payload changed while stalled");

  // a taken word blocks the input at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input open right after a word was taken");

  // the serial multiply keeps the input blocked after a word is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |-> ##16 in_stall_o)
    else $error("word finished faster than the serial multiply allows");

  // a new result only appears out of a busy phase
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result word without work in progress");

endmodule

bind hugoniot_thermostat_stepper_unit hts_checker u_hts_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_valid_i),
  .in_stall_o       (in_stall_o),
  .out_valid_o      (out_valid_o),
  .out_stall_i      (out_stall_i),
  .setpoint_out_o   (setpoint_out_o),
  .deviation_o      (deviation_o),
  .did_update_o     (did_update_o),
  .window_average_o (window_average_o)
);
